>>> hdl/robin_hood_hash_table_macros.svh
// Assertion macros for the robin hood hash table checker.
// No dependencies.
`ifndef ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define RH_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: label failed");
`define RH_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: label failed");
`endif

>>> hdl/rhht_pkg.sv
// Shared types and codes for the robin hood hash table.
// No dependencies.
`default_nettype none
package rhht_pkg;
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;
  localparam logic       OP_LOOKUP    = 1'b0;
  localparam logic       OP_INSERT    = 1'b1;
  localparam int         KEY_BITS     = 32;
  localparam int         FILL_BITS    = 10;

  // classified request handed from front to back
  typedef struct packed {
    logic                op;
    logic                refuse;   // insert refused as full
    logic [KEY_BITS-1:0] key;
  } req_t;
endpackage
`default_nettype wire

>>> hdl/robin_hood_hash_table.sv
// Robin Hood hash table. One transaction at a time: a probe reads memory, then
// compares/swaps, once per slot, before its result is given; the next input is
// taken once the sequencer is back in idle, and a stalled result holds off its
// processing. A refused insert skips the probe. The probe sequencer sets the rate.
// Synchronous active-low reset; a clearing pass over all SLOTS slots follows reset,
// during which no item is taken (configuration is always accepted).
`default_nettype none
module robin_hood_hash_table #(
  parameter int SLOTS = 1024,
  parameter int VALUE_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   in_op,
  input  wire [31:0]            in_key,
  input  wire [VALUE_BITS-1:0]  in_value,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [1:0]            out_status,
  output logic [9:0]            out_slot,
  output logic [15:0]           out_found_value,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [9:0]             cfg_data
);
  import rhht_pkg::*;
  localparam int AW = $clog2(SLOTS);
  localparam int CNT_BITS = AW + 1;
  logic [9:0]          fill_r;
  logic [CNT_BITS-1:0] count_r;
  logic                q_valid, q_pop, busy, push_ins, fstall;
  req_t                q_req;
  logic [VALUE_BITS-1:0] q_value;

  assign cfg_ready = 1'b1;
  assign in_stall = fstall || busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 10'd921; count_r <= '0;
    end else begin
      if (cfg_valid) fill_r <= cfg_data;
      if (push_ins && !busy) count_r <= CNT_BITS'(count_r + 1'b1);
    end
  end

  rhht_front #(.VALUE_BITS(VALUE_BITS), .CNT_BITS(CNT_BITS), .DEPTH(2)) u_front (
    .clk, .rst_n, .in_valid(in_valid && !busy), .in_stall(fstall), .in_op, .in_key,
    .in_value, .fill_limit(fill_r), .count_eff(count_r), .q_valid, .q_pop,
    .q_req, .q_value, .push_ins
  );

  rhht_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS), .AW(AW)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_req, .q_value, .busy, .out_valid,
    .out_stall, .out_status, .out_slot, .out_found_value
  );
endmodule
`default_nettype wire

>>> hdl/rhht_front.sv
// Front end: accepts transactions, classifies them, queues them for the back end.
// Depends on rhht_pkg.
`default_nettype none
module rhht_front #(
  parameter int VALUE_BITS = 16,
  parameter int CNT_BITS = 11,
  parameter int DEPTH = 2
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire                        in_op,
  input  wire [31:0]                 in_key,
  input  wire [VALUE_BITS-1:0]       in_value,
  input  wire [9:0]                  fill_limit,
  input  wire [CNT_BITS-1:0]         count_eff,
  output logic                       q_valid,
  input  wire                        q_pop,
  output rhht_pkg::req_t             q_req,
  output logic [VALUE_BITS-1:0]      q_value,
  output logic                       push_ins
);
  import rhht_pkg::*;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  req_t                  req_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          push;
  req_t          req_in;

  // serialize: only push when queue and back are empty, so count_eff is exact
  assign in_stall = (cnt_r != '0) || q_pop;
  assign push     = in_valid && !in_stall;
  assign push_ins = push && !req_in.refuse && (in_op == OP_INSERT);

  always_comb begin
    req_in.op     = in_op;
    req_in.key    = in_key;
    req_in.refuse = (in_key == '0) ||
                    (count_eff >= {{(CNT_BITS-10){1'b0}}, fill_limit}) ||
                    (count_eff[CNT_BITS-1]);
    wp_nxt  = push  ? PW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = q_pop ? PW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      req_mem[wp_r] <= req_in;
      val_mem[wp_r] <= in_value;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_req   = req_mem[rp_r];
  assign q_value = val_mem[rp_r];
endmodule
`default_nettype wire

>>> hdl/rhht_back.sv
// Back end: probe sequencer over key/value memories, clear sweep, result register.
// Depends on rhht_pkg.
`default_nettype none
module rhht_back #(
  parameter int SLOTS = 1024,
  parameter int VALUE_BITS = 16,
  parameter int AW = 10
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  output logic                  q_pop,
  input  rhht_pkg::req_t        q_req,
  input  wire [VALUE_BITS-1:0]  q_value,
  output logic                  busy,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [1:0]            out_status,
  output logic [9:0]            out_slot,
  output logic [15:0]           out_found_value
);
  import rhht_pkg::*;
  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_READ = 3'd2,
                         S_EVAL = 3'd3, S_DONE = 3'd4;
  logic [KEY_BITS-1:0]   kmem [SLOTS];
  logic [VALUE_BITS-1:0] vmem [SLOTS];
  logic [2:0]            st_r, st_nxt;
  logic [AW-1:0]         pos_r, pos_nxt, dist_r, dist_nxt;
  logic [AW:0]           n_r, n_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt, rk_r;
  logic [VALUE_BITS-1:0] val_r, val_nxt, rv_r;
  logic                  op_r, op_nxt, placed_r, placed_nxt;
  logic [1:0]            sts_r, sts_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [VALUE_BITS-1:0] fv_r, fv_nxt;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;
  logic [AW-1:0]         rdist;
  logic                  ov_r, ov_nxt;

  assign rdist = AW'(pos_r - rk_r[AW-1:0]);

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; dist_nxt = dist_r; n_nxt = n_r;
    key_nxt = key_r; val_nxt = val_r; op_nxt = op_r; placed_nxt = placed_r;
    sts_nxt = sts_r; slot_nxt = slot_r; fv_nxt = fv_r; ov_nxt = ov_r;
    q_pop = 1'b0; we = 1'b0; waddr = pos_r; wkey = key_r; wval = val_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_CLEAR: begin
        we = 1'b1; wkey = '0;
        pos_nxt = AW'(pos_r + 1'b1);
        if (pos_r == AW'(SLOTS-1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid && !ov_nxt) begin
          q_pop = 1'b1;
          op_nxt = q_req.op; key_nxt = q_req.key; val_nxt = q_value;
          pos_nxt = q_req.key[AW-1:0]; dist_nxt = '0; n_nxt = '0;
          placed_nxt = 1'b0; slot_nxt = '0; fv_nxt = '0;
          if (q_req.op == OP_INSERT && q_req.refuse) begin
            sts_nxt = ST_FULL; st_nxt = S_DONE;
          end else begin
            sts_nxt = (q_req.op == OP_INSERT) ? ST_INSERTED : ST_NOT_FOUND;
            st_nxt = S_READ;
          end
        end
      end
      S_READ: st_nxt = S_EVAL;
      S_EVAL: begin
        pos_nxt = AW'(pos_r + 1'b1);
        dist_nxt = AW'(dist_r + 1'b1);
        n_nxt = n_r + 1'b1;
        if (op_r == OP_INSERT) begin
          if (rk_r == '0) begin
            we = 1'b1;
            if (!placed_r) slot_nxt = pos_r;
            st_nxt = S_DONE;
          end else if (rdist < dist_r) begin
            we = 1'b1;
            if (!placed_r) slot_nxt = pos_r;
            placed_nxt = 1'b1;
            key_nxt = rk_r; val_nxt = rv_r; dist_nxt = AW'(rdist + 1'b1);
            st_nxt = S_READ;
          end else begin
            st_nxt = S_READ;
          end
        end else begin
          if (rk_r == '0 || dist_r > rdist) begin
            st_nxt = S_DONE;
          end else if (rk_r == key_r) begin
            sts_nxt = ST_FOUND; slot_nxt = pos_r; fv_nxt = rv_r;
            st_nxt = S_DONE;
          end else if (n_r == (AW+1)'(SLOTS-1)) begin
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; pos_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pos_r <= pos_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt; n_r <= n_nxt; key_r <= key_nxt; val_r <= val_nxt;
    op_r <= op_nxt; placed_r <= placed_nxt; sts_r <= sts_nxt;
    slot_r <= slot_nxt; fv_r <= fv_nxt;
    if (st_nxt == S_DONE && st_r != S_DONE) begin
      out_status <= sts_nxt;
      out_slot <= 10'(slot_nxt);
      out_found_value <= 16'(fv_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      kmem[waddr] <= wkey;
      vmem[waddr] <= wval;
    end
    rk_r <= kmem[pos_r];
    rv_r <= vmem[pos_r];
  end

  assign out_valid = ov_r;
  assign busy = (st_r != S_IDLE);
endmodule
`default_nettype wire

>>> hdl/rhht_checker.sv
// Port-level checker for the robin hood hash table, bound to the top level.
// Depends on rhht_pkg and robin_hood_hash_table_macros.svh.
`default_nettype none
`include "robin_hood_hash_table_macros.svh"
module rhht_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire [1:0] out_status,
  input wire [15:0] out_found_value
);
  import rhht_pkg::*;
  `RH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `RH_ASSERT_NEXT(a_no_accept_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `RH_ASSERT_IMPL(a_fv_zero, clk, rst_n, out_valid && out_status != ST_FOUND, out_found_value == 16'd0)
endmodule
bind robin_hood_hash_table rhht_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_status,
  .out_found_value
);
`default_nettype wire

>>> tb/sv/tb_robin_hood_hash_table.sv
// Testbench for robin_hood_hash_table: directed and random insert/lookup traffic
// checked against a behavioral Robin Hood table model held in a scoreboard class.
// Depends on rhht_pkg and the robin_hood_hash_table RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_robin_hood_hash_table;
  import rhht_pkg::*;

  localparam int SLOTS = 1024;
  localparam int HOLD_LEN = 300;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [15:0] fval;
  } answer_t;

  class table_scoreboard;
    logic [31:0] keys[SLOTS];
    logic [15:0] vals[SLOTS];
    int          count;
    logic [9:0]  limit;
    answer_t     pending[$];
    int          errors;
    int          checked;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        keys[i] = '0;
        vals[i] = '0;
      end
      count = 0;
      limit = 10'd921;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function int distance(logic [31:0] k, int pos);
      return (pos + SLOTS - int'(k[9:0])) % SLOTS;
    endfunction

    // predict the answer for one accepted transaction and update the table
    function void note_request(logic op, logic [31:0] key_in, logic [15:0] val_in);
      answer_t     a;
      logic [31:0] k, rk;
      logic [15:0] v, rv;
      int          pos, pdist, rd;
      bit          placed;
      a.status = ST_NOT_FOUND;
      a.slot = '0;
      a.fval = '0;
      k = key_in;
      v = val_in;
      pos = int'(k[9:0]);
      pdist = 0;
      placed = 0;
      if (op == OP_INSERT) begin
        if (k == 0 || count >= int'(limit) || count >= SLOTS) begin
          a.status = ST_FULL;
        end else begin
          for (int n = 0; n < SLOTS; n++) begin
            rk = keys[pos];
            if (rk == 0) begin
              keys[pos] = k;
              vals[pos] = v;
              if (!placed) a.slot = pos[9:0];
              break;
            end
            rd = distance(rk, pos);
            if (rd < pdist) begin
              rv = vals[pos];
              keys[pos] = k;
              vals[pos] = v;
              if (!placed) begin
                a.slot = pos[9:0];
                placed = 1;
              end
              k = rk;
              v = rv;
              pdist = rd;
            end
            pos = (pos + 1) % SLOTS;
            pdist++;
          end
          count++;
          a.status = ST_INSERTED;
        end
      end else begin
        for (int n = 0; n < SLOTS; n++) begin
          rk = keys[pos];
          if (rk == 0) break;
          if (pdist > distance(rk, pos)) break;
          if (rk == k) begin
            a.status = ST_FOUND;
            a.slot = pos[9:0];
            a.fval = vals[pos];
            break;
          end
          pos = (pos + 1) % SLOTS;
          pdist++;
        end
      end
      pending.push_back(a);
    endfunction

    function void check_answer(logic [1:0] st, logic [9:0] sl, logic [15:0] fv);
      answer_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d value=%0h", $time, st, sl, fv);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (sl !== e.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, e.slot, sl);
        errors++;
      end
      if (fv !== e.fval) begin
        $display("%0t: found_value expected %0h actual %0h", $time, e.fval, fv);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [31:0] in_key;
  logic [15:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [9:0]  out_slot;
  logic [15:0] out_found_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [9:0]  cfg_data;

  robin_hood_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_key(in_key),
    .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_slot(out_slot), .out_found_value(out_found_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  table_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_tog;       // toggled to request a long receiver hold-off
  logic hold_seen;
  int hold_left;        // long receiver hold-off, counted in the receiver process
  logic [31:0] used_keys[$];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stall plus optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= hold_tog;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_answer(out_status, out_slot, out_found_value);
      if (hold_tog != hold_seen) begin
        hold_seen <= hold_tog;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send(logic op, logic [31:0] k, logic [15:0] v);
    while (($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= k;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, k, v);
    if (op == OP_INSERT && k != 0) used_keys.push_back(k);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [9:0] lim);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.limit = lim;
  endtask

  function automatic logic [31:0] pick_key(int mode);
    // clustered keys share low bits so probe chains and swaps happen
    case (mode)
      0: return {16'($urandom_range(32'hFFFF)), 6'd0, 10'($urandom_range(15))};
      1: return used_keys.size() ? used_keys[$urandom_range(used_keys.size() - 1)]
                                 : 32'd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int items, int idle, int stall);
    int mode;
    logic op;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      mode = $urandom_range(2);
      op = 1'($urandom_range(1));
      send(op, pick_key(mode), 16'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = 1'b0;
    in_key = '0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_tog = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero key, wrap, displacement, miss, refusal
    send(OP_LOOKUP, 32'h0, 16'h0);
    send(OP_INSERT, 32'h0, 16'hFFFF);
    send(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send(OP_INSERT, 32'h0000_07FF, 16'h0001);
    send(OP_INSERT, 32'h0000_0BFF, 16'h8000);
    send(OP_INSERT, 32'h0000_0400, 16'h1234);
    send(OP_INSERT, 32'h0000_0001, 16'h0000);
    send(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0);
    send(OP_LOOKUP, 32'h0000_0BFF, 16'h0);
    send(OP_LOOKUP, 32'h0000_0400, 16'h0);
    send(OP_LOOKUP, 32'h0000_0001, 16'h0);
    send(OP_LOOKUP, 32'h0000_13FF, 16'h0);
    send(OP_LOOKUP, 32'h0000_0002, 16'h0);
    write_limit(10'd7);
    send(OP_INSERT, 32'h0000_0005, 16'h5555);
    send(OP_INSERT, 32'h0000_0006, 16'hAAAA);
    send(OP_LOOKUP, 32'h0000_0006, 16'h0);
    write_limit(10'd0);
    send(OP_INSERT, 32'h0000_0009, 16'h1);
    write_limit(10'd1023);

    random_phase(400, 0, 0);
    // long receiver hold-off while the sender keeps offering
    hold_tog = ~hold_tog;
    random_phase(100, 0, 0);
    drain();
    random_phase(400, 54, 0);
    random_phase(400, 0, 54);
    write_limit(10'd1);
    random_phase(50, 20, 20);
    write_limit(10'd1023);
    random_phase(400, 20, 20);
    drain();
    // pushes the table to the refusal point and beyond
    write_limit(10'd921);
    random_phase(200, 20, 20);
    drain();

    $display("Covered %0d results: lookups and inserts with clustering, wrap,", sb.checked);
    $display("fill limits 0/1/7/921/1023, and all idle and stall mixes.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
